/* design/utf8_glyph_shaper_top_assert.svh */
// Assertion macros used by the glyph shaper top level.
`ifndef UTF8_GLYPH_SHAPER_TOP_ASSERT_SVH
`define UTF8_GLYPH_SHAPER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Antecedent and consequent in the same cycle.
`define UGS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Consequent in the cycle after the antecedent.
`define UGS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define UGS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define UGS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* design/ugs_pkg.sv */
package ugs_pkg;

   localparam int unsigned BYTE_BITS       = 8;
   localparam int unsigned CODE_BITS       = 21;
   localparam int unsigned OUT_OFFSET_BITS = 16;
   localparam int unsigned ADV_BITS        = 16;
   localparam int unsigned EM_BITS         = 16;
   localparam int unsigned FACE_BITS       = 16;
   localparam int unsigned CSR_INDEX_BITS  = 3;
   localparam int unsigned CSR_DATA_BITS   = 16;

   localparam logic [EM_BITS-1:0] EM_SIZE_RESET = 16'd1024;

   // 1/5 of a value below 2^18 is (x * 52429) >> 18, exact after truncation.
   localparam logic [15:0] FIFTH_RECIP = 16'd52429;
   localparam int unsigned FIFTH_SHIFT = 18;

   localparam logic [CODE_BITS-1:0] REPLACEMENT_CODE = 21'h00FFFD;
   localparam logic [CODE_BITS-1:0] LATIN_LIMIT      = 21'h00024F;
   localparam logic [CODE_BITS-1:0] KANA_LO          = 21'h003040;
   localparam logic [CODE_BITS-1:0] KANA_HI          = 21'h0030FF;
   localparam logic [CODE_BITS-1:0] HANGUL_LO        = 21'h00AC00;
   localparam logic [CODE_BITS-1:0] HANGUL_HI        = 21'h00D7AF;
   localparam logic [CODE_BITS-1:0] HAN_LO           = 21'h004E00;
   localparam logic [CODE_BITS-1:0] HAN_HI           = 21'h009FFF;
   localparam logic [CODE_BITS-1:0] EMOJI_LO         = 21'h01F300;
   localparam logic [CODE_BITS-1:0] EMOJI_HI         = 21'h01FAFF;
   localparam logic [CODE_BITS-1:0] SYMBOL_LO        = 21'h002600;
   localparam logic [CODE_BITS-1:0] SYMBOL_HI        = 21'h0027BF;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_EM_SIZE       = 3'd0,
      CSR_FACE_ID       = 3'd1,
      CSR_FACE_PRESENT  = 3'd2,
      CSR_EMOJI_COLOUR  = 3'd3,
      CSR_RIGHT_TO_LEFT = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GLYPH_A,
      ST_GLYPH_B,
      ST_TAIL,
      ST_POP,
      ST_DRAIN,
      ST_FLUSH
   } ctrl_state_type;

   typedef enum logic [1:0] {
      SRC_NONE,
      SRC_A,
      SRC_B,
      SRC_TAIL
   } make_src_type;

   typedef struct packed {
      logic         load;
      make_src_type make_src;
      logic         pop;
      logic         drain_emit;
      logic         flush;
   } ugs_cmd_type;

   typedef struct packed {
      logic glyph_a_valid;
      logic glyph_b_valid;
      logic tail_more;
      logic stack_nonempty;
      logic face_present;
      logic end_of_text;
      logic make_blocked;
      logic emit_ready;
      logic pend_valid;
   } ugs_status_type;

endpackage

/* design/ugs_ram.sv */
module ugs_ram #(
   parameter int unsigned WIDTH = 37,
   parameter int unsigned DEPTH = 64,
   localparam int unsigned ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/ugs_ctrl.sv */
module ugs_ctrl
   import ugs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  ugs_status_type status,
   output ugs_cmd_type    cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_GLYPH_A;
            end
         end
         ST_GLYPH_A: begin
            if (!status.glyph_a_valid || !status.make_blocked) begin
               state_in = ST_GLYPH_B;
            end
         end
         ST_GLYPH_B: begin
            if (!status.glyph_b_valid || !status.make_blocked) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            if (!status.tail_more) begin
               state_in = status.end_of_text ? ST_POP : ST_FLUSH;
            end
         end
         ST_POP: begin
            if (status.face_present && status.stack_nonempty) begin
               state_in = ST_DRAIN;
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_DRAIN: begin
            if (status.emit_ready) begin
               state_in = ST_POP;
            end
         end
         ST_FLUSH: begin
            if (status.emit_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_GLYPH_A: begin
            if (status.glyph_a_valid && !status.make_blocked) begin
               cmd.make_src = SRC_A;
            end
         end
         ST_GLYPH_B: begin
            if (status.glyph_b_valid && !status.make_blocked) begin
               cmd.make_src = SRC_B;
            end
         end
         ST_TAIL: begin
            if (status.tail_more && !status.make_blocked) begin
               cmd.make_src = SRC_TAIL;
            end
         end
         ST_POP: begin
            cmd.pop = status.face_present && status.stack_nonempty;
         end
         ST_DRAIN: begin
            cmd.drain_emit = status.emit_ready;
         end
         ST_FLUSH: begin
            cmd.flush = status.emit_ready;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

/* design/ugs_datapath.sv */
module ugs_datapath
   import ugs_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = 64,
   parameter int unsigned OFFSET_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [BYTE_BITS-1:0]       req_text_byte,
   input  logic                       req_end_of_text,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_write_data,
   input  logic                       rsp_stall,
   output logic                       rsp_valid,
   output logic [CODE_BITS-1:0]       rsp_glyph_code,
   output logic [OUT_OFFSET_BITS-1:0] rsp_byte_offset,
   output logic [ADV_BITS-1:0]        rsp_advance,
   output logic                       rsp_colour_glyph,
   output logic [FACE_BITS-1:0]       rsp_glyph_face,
   output logic                       rsp_dropped,
   output logic                       rsp_last_glyph,
   input  ugs_cmd_type                cmd,
   output ugs_status_type             status
);

   localparam int unsigned ADDR_BITS    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int unsigned COUNT_BITS   = $clog2(STACK_DEPTH + 1);
   localparam int unsigned WIDE_BITS    = (OFFSET_BITS > OUT_OFFSET_BITS) ?
                                          OFFSET_BITS : OUT_OFFSET_BITS;
   localparam int unsigned ENTRY_BITS   = CODE_BITS + OUT_OFFSET_BITS;
   localparam int unsigned EM3_BITS     = EM_BITS + 2;
   localparam int unsigned PRODUCT_BITS = EM3_BITS + 16;

   function automatic logic is_wide_code(input logic [CODE_BITS-1:0] code);
      return (code >= KANA_LO && code <= KANA_HI) ||
             (code >= HANGUL_LO && code <= HANGUL_HI) ||
             (code >= HAN_LO && code <= HAN_HI);
   endfunction

   function automatic logic is_emoji_code(input logic [CODE_BITS-1:0] code);
      return (code >= EMOJI_LO && code <= EMOJI_HI) ||
             (code >= SYMBOL_LO && code <= SYMBOL_HI);
   endfunction

   // Configuration registers.
   logic [EM_BITS-1:0]   em_size_ff;
   logic [FACE_BITS-1:0] face_id_ff;
   logic                 face_present_ff;
   logic                 emoji_colour_ff;
   logic                 right_to_left_ff;

   // Decoder state.
   logic [CODE_BITS-1:0]   partial_ff;
   logic [2:0]             bytes_expected_ff;
   logic [2:0]             bytes_seen_ff;
   logic [OFFSET_BITS-1:0] sequence_start_ff;
   logic [OFFSET_BITS-1:0] byte_position_ff;
   logic                   end_ff;

   // Glyphs raised by the current item.
   logic                   glyph_a_valid_ff;
   logic [CODE_BITS-1:0]   glyph_a_code_ff;
   logic [OFFSET_BITS-1:0] glyph_a_offset_ff;
   logic                   glyph_b_valid_ff;
   logic [CODE_BITS-1:0]   glyph_b_code_ff;
   logic [OFFSET_BITS-1:0] glyph_b_offset_ff;
   logic [1:0]             tail_count_ff;
   logic [1:0]             tail_index_ff;
   logic [OFFSET_BITS-1:0] tail_base_ff;

   // Decode of the incoming byte.
   logic                   dec_a_valid;
   logic [CODE_BITS-1:0]   dec_a_code;
   logic                   dec_b_valid;
   logic [CODE_BITS-1:0]   dec_b_code;
   logic [CODE_BITS-1:0]   dec_partial;
   logic [2:0]             dec_expected;
   logic [2:0]             dec_seen;
   logic [OFFSET_BITS-1:0] dec_start;
   logic                   dec_lead;
   logic [CODE_BITS-1:0]   cont_code;
   logic [2:0]             seen_inc;

   // Stack.
   logic [COUNT_BITS-1:0] stack_count_ff;
   logic                  overflowed_ff;
   logic                  stack_full;
   logic [COUNT_BITS-1:0] pop_index;
   logic [ENTRY_BITS-1:0] stack_rd_data;
   logic                  stack_wr_en;

   // Glyph making and emission.
   logic                       make_valid;
   logic                       make_push;
   logic                       make_emit;
   logic [CODE_BITS-1:0]       make_code;
   logic [OFFSET_BITS-1:0]     make_offset;
   logic [WIDE_BITS-1:0]       make_offset_wide;
   logic [CODE_BITS-1:0]       emit_code;
   logic [OUT_OFFSET_BITS-1:0] emit_offset;
   logic                       emit_drop;
   logic                       emit_wide;
   logic                       emit_emoji;
   logic [ADV_BITS-1:0]        emit_advance;
   logic                       emit_colour;
   logic [EM3_BITS-1:0]        em_times_three;
   logic [PRODUCT_BITS-1:0]    fifth_product;
   logic [ADV_BITS-1:0]        narrow_advance;

   // Holding stage and output register.
   logic                       pend_valid_ff;
   logic [CODE_BITS-1:0]       pend_code_ff;
   logic [OUT_OFFSET_BITS-1:0] pend_offset_ff;
   logic [ADV_BITS-1:0]        pend_advance_ff;
   logic                       pend_colour_ff;
   logic [FACE_BITS-1:0]       pend_face_ff;
   logic                       pend_drop_ff;
   logic                       out_valid_ff;
   logic [CODE_BITS-1:0]       out_code_ff;
   logic [OUT_OFFSET_BITS-1:0] out_offset_ff;
   logic [ADV_BITS-1:0]        out_advance_ff;
   logic                       out_colour_ff;
   logic [FACE_BITS-1:0]       out_face_ff;
   logic                       out_drop_ff;
   logic                       out_last_ff;
   logic                       out_free;
   logic                       emit_ready;
   logic                       pend_write;
   logic                       pend_to_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         em_size_ff       <= EM_SIZE_RESET;
         face_id_ff       <= '0;
         face_present_ff  <= 1'b1;
         emoji_colour_ff  <= 1'b0;
         right_to_left_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_EM_SIZE:       em_size_ff       <= csr_write_data[EM_BITS-1:0];
            CSR_FACE_ID:       face_id_ff       <= csr_write_data[FACE_BITS-1:0];
            CSR_FACE_PRESENT:  face_present_ff  <= csr_write_data[0];
            CSR_EMOJI_COLOUR:  emoji_colour_ff  <= csr_write_data[0];
            CSR_RIGHT_TO_LEFT: right_to_left_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   assign cont_code = {partial_ff[CODE_BITS-7:0], req_text_byte[5:0]};
   assign seen_inc  = bytes_seen_ff + 3'd1;

   always_comb begin
      dec_a_valid  = 1'b0;
      dec_a_code   = REPLACEMENT_CODE;
      dec_b_valid  = 1'b0;
      dec_b_code   = REPLACEMENT_CODE;
      dec_partial  = partial_ff;
      dec_expected = bytes_expected_ff;
      dec_seen     = bytes_seen_ff;
      dec_start    = sequence_start_ff;
      dec_lead     = 1'b0;
      if (bytes_expected_ff != 3'd0) begin
         if (req_text_byte[7:6] == 2'b10) begin
            dec_partial = cont_code;
            dec_seen    = seen_inc;
            if (seen_inc >= bytes_expected_ff) begin
               dec_a_valid  = 1'b1;
               dec_a_code   = cont_code;
               dec_partial  = '0;
               dec_expected = 3'd0;
               dec_seen     = 3'd0;
            end
         end else begin
            // Broken sequence: replacement at its start, byte read again as a lead.
            dec_a_valid  = 1'b1;
            dec_partial  = '0;
            dec_expected = 3'd0;
            dec_seen     = 3'd0;
            dec_lead     = 1'b1;
         end
      end else begin
         dec_lead = 1'b1;
      end
      if (dec_lead) begin
         priority if (req_text_byte[7] == 1'b0) begin
            dec_b_valid = 1'b1;
            dec_b_code  = CODE_BITS'(req_text_byte);
         end else if (req_text_byte[7:5] == 3'b110) begin
            dec_partial  = CODE_BITS'(req_text_byte[4:0]);
            dec_expected = 3'd2;
            dec_seen     = 3'd1;
            dec_start    = byte_position_ff;
         end else if (req_text_byte[7:4] == 4'b1110) begin
            dec_partial  = CODE_BITS'(req_text_byte[3:0]);
            dec_expected = 3'd3;
            dec_seen     = 3'd1;
            dec_start    = byte_position_ff;
         end else if (req_text_byte[7:3] == 5'b11110) begin
            dec_partial  = CODE_BITS'(req_text_byte[2:0]);
            dec_expected = 3'd4;
            dec_seen     = 3'd1;
            dec_start    = byte_position_ff;
         end else begin
            dec_b_valid = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff        <= '0;
         bytes_expected_ff <= '0;
         bytes_seen_ff     <= '0;
         sequence_start_ff <= '0;
         byte_position_ff  <= '0;
         end_ff            <= 1'b0;
         glyph_a_valid_ff  <= 1'b0;
         glyph_b_valid_ff  <= 1'b0;
         tail_count_ff     <= '0;
         tail_index_ff     <= '0;
      end else if (cmd.load) begin
         glyph_a_valid_ff <= dec_a_valid;
         glyph_b_valid_ff <= dec_b_valid;
         end_ff           <= req_end_of_text;
         tail_index_ff    <= '0;
         if (req_end_of_text) begin
            partial_ff        <= '0;
            bytes_expected_ff <= '0;
            bytes_seen_ff     <= '0;
            sequence_start_ff <= '0;
            byte_position_ff  <= '0;
            tail_count_ff     <= (dec_expected != 3'd0) ? dec_seen[1:0] : 2'd0;
         end else begin
            partial_ff        <= dec_partial;
            bytes_expected_ff <= dec_expected;
            bytes_seen_ff     <= dec_seen;
            sequence_start_ff <= dec_start;
            byte_position_ff  <= byte_position_ff + OFFSET_BITS'(1);
            tail_count_ff     <= '0;
         end
      end else if (cmd.make_src == SRC_TAIL) begin
         tail_index_ff <= tail_index_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         glyph_a_code_ff   <= dec_a_code;
         glyph_a_offset_ff <= sequence_start_ff;
         glyph_b_code_ff   <= dec_b_code;
         glyph_b_offset_ff <= byte_position_ff;
         tail_base_ff      <= dec_start;
      end
   end

   always_comb begin
      unique case (cmd.make_src)
         SRC_NONE, SRC_A: begin
            make_code   = glyph_a_code_ff;
            make_offset = glyph_a_offset_ff;
         end
         SRC_B: begin
            make_code   = glyph_b_code_ff;
            make_offset = glyph_b_offset_ff;
         end
         SRC_TAIL: begin
            make_code   = REPLACEMENT_CODE;
            make_offset = tail_base_ff + OFFSET_BITS'(tail_index_ff);
         end
      endcase
   end

   assign make_offset_wide = WIDE_BITS'(make_offset);
   assign make_valid       = (cmd.make_src != SRC_NONE);
   assign make_push        = make_valid && face_present_ff && right_to_left_ff;
   assign make_emit        = make_valid && face_present_ff && !right_to_left_ff;

   assign stack_full  = (stack_count_ff == COUNT_BITS'(STACK_DEPTH));
   assign stack_wr_en = make_push && !stack_full;
   assign pop_index   = stack_count_ff - COUNT_BITS'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         stack_count_ff <= '0;
         overflowed_ff  <= 1'b0;
      end else if (cmd.flush && end_ff) begin
         stack_count_ff <= '0;
         overflowed_ff  <= 1'b0;
      end else if (make_push) begin
         if (stack_full) begin
            overflowed_ff <= 1'b1;
         end else begin
            stack_count_ff <= stack_count_ff + COUNT_BITS'(1);
         end
      end else if (cmd.pop) begin
         stack_count_ff <= pop_index;
      end
   end

   ugs_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stack_wr_en),
      .wr_addr (stack_count_ff[ADDR_BITS-1:0]),
      .wr_data ({make_offset_wide[OUT_OFFSET_BITS-1:0], make_code}),
      .rd_en   (cmd.pop),
      .rd_addr (pop_index[ADDR_BITS-1:0]),
      .rd_data (stack_rd_data)
   );

   assign emit_code   = cmd.drain_emit ? stack_rd_data[CODE_BITS-1:0] : make_code;
   assign emit_offset = cmd.drain_emit ? stack_rd_data[ENTRY_BITS-1:CODE_BITS]
                                       : make_offset_wide[OUT_OFFSET_BITS-1:0];
   assign emit_drop   = cmd.drain_emit && overflowed_ff;

   // 0.6 em is em * 3 / 5, taken by a reciprocal multiply.
   assign em_times_three = EM3_BITS'(em_size_ff) + {1'b0, em_size_ff, 1'b0};
   assign fifth_product  = PRODUCT_BITS'(em_times_three) * PRODUCT_BITS'(FIFTH_RECIP);
   assign narrow_advance = fifth_product[FIFTH_SHIFT +: ADV_BITS];

   assign emit_wide    = (emit_code > LATIN_LIMIT) && is_wide_code(emit_code);
   assign emit_emoji   = (emit_code > LATIN_LIMIT) && !emit_wide && is_emoji_code(emit_code);
   assign emit_advance = (emit_wide || emit_emoji) ? em_size_ff : narrow_advance;
   assign emit_colour  = emit_emoji && emoji_colour_ff;

   assign out_free    = !out_valid_ff || !rsp_stall;
   assign emit_ready  = !pend_valid_ff || out_free;
   assign pend_write  = make_emit || cmd.drain_emit;
   assign pend_to_out = pend_valid_ff && out_free && (pend_write || cmd.flush);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (pend_write) begin
            pend_valid_ff <= 1'b1;
         end else if (pend_to_out) begin
            pend_valid_ff <= 1'b0;
         end
         if (pend_to_out) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pend_write) begin
         pend_code_ff    <= emit_code;
         pend_offset_ff  <= emit_offset;
         pend_advance_ff <= emit_advance;
         pend_colour_ff  <= emit_colour;
         pend_face_ff    <= face_id_ff;
         pend_drop_ff    <= emit_drop;
      end
      if (pend_to_out) begin
         out_code_ff    <= pend_code_ff;
         out_offset_ff  <= pend_offset_ff;
         out_advance_ff <= pend_advance_ff;
         out_colour_ff  <= pend_colour_ff;
         out_face_ff    <= pend_face_ff;
         out_drop_ff    <= pend_drop_ff;
         out_last_ff    <= cmd.flush && end_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_glyph_code   = out_code_ff;
   assign rsp_byte_offset  = out_offset_ff;
   assign rsp_advance      = out_advance_ff;
   assign rsp_colour_glyph = out_colour_ff;
   assign rsp_glyph_face   = out_face_ff;
   assign rsp_dropped      = out_drop_ff;
   assign rsp_last_glyph   = out_last_ff;

   assign status.glyph_a_valid  = glyph_a_valid_ff;
   assign status.glyph_b_valid  = glyph_b_valid_ff;
   assign status.tail_more      = (tail_index_ff < tail_count_ff);
   assign status.stack_nonempty = (stack_count_ff != '0);
   assign status.face_present   = face_present_ff;
   assign status.end_of_text    = end_ff;
   assign status.make_blocked   = face_present_ff && !right_to_left_ff && !emit_ready;
   assign status.emit_ready     = emit_ready;
   assign status.pend_valid     = pend_valid_ff;

endmodule

/* design/utf8_glyph_shaper_top.sv */
// utf8_glyph_shaper_top: UTF-8 text bytes in, one item per byte; shaped glyph items out.
// Items are not overlapped: a new byte item is taken only in the idle state. Each item goes
// through the glyph A, glyph B and tail states, with one replacement glyph in the tail for
// each byte of a sequence cut off at end of text; an end-of-text item then checks the stack
// and pops and emits each stacked glyph. A stall on the result side can hold the item.
// Reset (synchronous, active high) restores register defaults and empties the stack at once.
`include "utf8_glyph_shaper_top_assert.svh"

module utf8_glyph_shaper_top
   import ugs_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = 64,
   parameter int unsigned OFFSET_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   // Byte items.
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [BYTE_BITS-1:0]       req_text_byte,
   input  logic                       req_end_of_text,
   // Glyph items.
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [CODE_BITS-1:0]       rsp_glyph_code,
   output logic [OUT_OFFSET_BITS-1:0] rsp_byte_offset,
   output logic [ADV_BITS-1:0]        rsp_advance,
   output logic                       rsp_colour_glyph,
   output logic [FACE_BITS-1:0]       rsp_glyph_face,
   output logic                       rsp_dropped,
   output logic                       rsp_last_glyph,
   // Register writes.
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_write_data
);

   // The controller walks each byte item through a fixed sequence of slots:
   // the glyph finished or abandoned by the open sequence, the glyph of the
   // byte read as a lead byte, the replacement glyphs of a sequence cut off at
   // end of text, and finally the drain of the right-to-left stack. Every
   // glyph made in left-to-right mode with a face goes into a one-deep holding
   // stage in the datapath; it moves on to the output register when the next
   // glyph arrives, or when the item closes, at which point the end-of-text
   // flag of the item tells whether it is the last glyph of the string.
   ugs_cmd_type    cmd;
   ugs_status_type status;

   ugs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the registers, the decoder state, the stack memory,
   // the advance arithmetic and the output stages. The output register
   // separates the result side from the rest, so a stalled glyph does not
   // stop the making of the next one until the holding stage is full too.
   ugs_datapath #(
      .STACK_DEPTH (STACK_DEPTH),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_text_byte    (req_text_byte),
      .req_end_of_text  (req_end_of_text),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_glyph_code   (rsp_glyph_code),
      .rsp_byte_offset  (rsp_byte_offset),
      .rsp_advance      (rsp_advance),
      .rsp_colour_glyph (rsp_colour_glyph),
      .rsp_glyph_face   (rsp_glyph_face),
      .rsp_dropped      (rsp_dropped),
      .rsp_last_glyph   (rsp_last_glyph),
      .cmd              (cmd),
      .status           (status)
   );

   // An accepted byte item always takes the controller out of its idle state.
   `UGS_ASSERT_NEXT(a_accept_goes_busy, clock, reset, req_valid && !req_stall, req_stall, "byte item accepted but controller stayed idle")
   // Each item closes by moving its held glyph out, so idle means the holding stage is empty.
   `UGS_ASSERT_IMPLY(a_idle_pend_empty, clock, reset, !req_stall, !status.pend_valid, "glyph left in holding stage while idle")
   // Cut-off replacement glyphs are only ever pending for an end-of-text item.
   `UGS_ASSERT_IMPLY(a_tail_only_at_end, clock, reset, status.tail_more, status.end_of_text, "replacement tail pending without end of text")

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

// Testbench for utf8_glyph_shaper_top.
//
// Byte items go in on the req_ channel and glyph items come back on the rsp_ channel. Every
// accepted byte is run through a shaping predictor held in this module. The predictor keeps
// its own copy of the decoder state, the right-to-left stack and the registers. The glyphs
// that it predicts are queued, and each glyph that the block hands over is compared with the
// oldest one in the queue.
//
// The run has two parts. A short directed string comes first. Its single-byte rows carry
// their expected glyph in the table itself. After that come several random phases, each with
// its own register setting and its own idling pattern.
module tb_top;
   import ugs_pkg::*;

   localparam int unsigned STACK_SLOTS = 64;
   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned REPORT_LIMIT = 10;

   // One glyph item as it appears on the result ports.
   typedef struct packed {
      logic [CODE_BITS-1:0]       code;
      logic [OUT_OFFSET_BITS-1:0] offset;
      logic [ADV_BITS-1:0]        advance;
      logic                       colour;
      logic [FACE_BITS-1:0]       face;
      logic                       dropped;
      logic                       last;
   } glyph_type;

   // A glyph parked on the right-to-left stack until the end of its string.
   typedef struct packed {
      logic [CODE_BITS-1:0]       code;
      logic [OUT_OFFSET_BITS-1:0] offset;
   } stacked_glyph_type;

   // A row of the directed string. Where typed is set, the row is a whole one-byte string
   // sent under the reset registers, and its single glyph is given here directly.
   typedef struct packed {
      logic [7:0]           text_byte;
      logic                 eot;
      logic                 typed;
      logic [CODE_BITS-1:0] code;
   } text_row_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [BYTE_BITS-1:0]       req_text_byte;
   logic                       req_end_of_text;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [CODE_BITS-1:0]       rsp_glyph_code;
   logic [OUT_OFFSET_BITS-1:0] rsp_byte_offset;
   logic [ADV_BITS-1:0]        rsp_advance;
   logic                       rsp_colour_glyph;
   logic [FACE_BITS-1:0]       rsp_glyph_face;
   logic                       rsp_dropped;
   logic                       rsp_last_glyph;
   logic                       csr_write_enable;
   logic [CSR_INDEX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0]   csr_write_data;

   // The predictor's copy of the registers. It starts from the reset values.
   logic [EM_BITS-1:0]   em_size = EM_SIZE_RESET;
   logic [FACE_BITS-1:0] face_number = '0;
   logic                 face_on = 1'b1;
   logic                 colour_on = 1'b0;
   logic                 rtl_on = 1'b0;

   // The predictor's copy of the decoder state.
   logic [CODE_BITS-1:0] seq_code = '0;
   logic [2:0]           seq_len = '0;
   logic [2:0]           seq_count = '0;
   logic [15:0]          seq_offset = '0;
   logic [15:0]          text_pos = '0;
   stacked_glyph_type    rtl_stack [STACK_SLOTS];
   int unsigned          rtl_depth = 0;
   logic                 rtl_lost = 1'b0;

   glyph_type   glyphs_due[$];
   logic [7:0]  text_bytes[$];
   int unsigned mismatch_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;

   // The directed string. The first four rows are complete strings of one byte each: the
   // lowest byte, a byte that can never appear in UTF-8, a stray continuation byte and the
   // highest ASCII byte. The rows after them form one string. It holds Han, Hangul, Kana, an
   // emoji, a dingbat symbol, a lead byte broken off by an ASCII byte, the largest code that
   // four bytes can carry, and a three-byte sequence cut off by the end of the text.
   text_row_type opening_rows [28] = '{
      '{8'h00, 1'b1, 1'b1, 21'h000000},
      '{8'hFF, 1'b1, 1'b1, REPLACEMENT_CODE},
      '{8'h80, 1'b1, 1'b1, REPLACEMENT_CODE},
      '{8'h7F, 1'b1, 1'b1, 21'h00007F},
      '{8'hE4, 1'b0, 1'b0, '0}, '{8'hB8, 1'b0, 1'b0, '0}, '{8'h80, 1'b0, 1'b0, '0},
      '{8'hEA, 1'b0, 1'b0, '0}, '{8'hB0, 1'b0, 1'b0, '0}, '{8'h80, 1'b0, 1'b0, '0},
      '{8'hE3, 1'b0, 1'b0, '0}, '{8'h81, 1'b0, 1'b0, '0}, '{8'h82, 1'b0, 1'b0, '0},
      '{8'hF0, 1'b0, 1'b0, '0}, '{8'h9F, 1'b0, 1'b0, '0}, '{8'h98, 1'b0, 1'b0, '0},
      '{8'h80, 1'b0, 1'b0, '0},
      '{8'hE2, 1'b0, 1'b0, '0}, '{8'h98, 1'b0, 1'b0, '0}, '{8'h80, 1'b0, 1'b0, '0},
      '{8'hC3, 1'b0, 1'b0, '0}, '{8'h41, 1'b0, 1'b0, '0},
      '{8'hF7, 1'b0, 1'b0, '0}, '{8'hBF, 1'b0, 1'b0, '0}, '{8'hBF, 1'b0, 1'b0, '0},
      '{8'hBF, 1'b0, 1'b0, '0},
      '{8'hE4, 1'b0, 1'b0, '0}, '{8'hB8, 1'b1, 1'b0, '0}
   };

   utf8_glyph_shaper_top #(
      .STACK_DEPTH(STACK_SLOTS),
      .OFFSET_BITS(16)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_byte    (req_text_byte),
      .req_end_of_text  (req_end_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_glyph_code   (rsp_glyph_code),
      .rsp_byte_offset  (rsp_byte_offset),
      .rsp_advance      (rsp_advance),
      .rsp_colour_glyph (rsp_colour_glyph),
      .rsp_glyph_face   (rsp_glyph_face),
      .rsp_dropped      (rsp_dropped),
      .rsp_last_glyph   (rsp_last_glyph),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------------------------
   // Shaping predictor
   // ------------------------------------------------------------------------------------

   // Builds a finished glyph and queues it. The advance is 0.6em, with the fraction
   // truncated. Wide scripts get the full em, and so do emoji, which also take the colour
   // flag. Anything up to the end of Latin Extended-B is never wide.
   function automatic void send_glyph(logic [CODE_BITS-1:0] code, logic [15:0] offset,
                                      logic lost);
      glyph_type   g;
      logic [31:0] scaled;
      scaled = (32'(em_size) * 32'd60) / 32'd100;
      g.advance = scaled[15:0];
      g.colour = 1'b0;
      if (code > LATIN_LIMIT) begin
         if ((code >= KANA_LO && code <= KANA_HI) || (code >= HANGUL_LO && code <= HANGUL_HI)
             || (code >= HAN_LO && code <= HAN_HI)) begin
            g.advance = em_size;
         end else if ((code >= EMOJI_LO && code <= EMOJI_HI)
                      || (code >= SYMBOL_LO && code <= SYMBOL_HI)) begin
            g.advance = em_size;
            g.colour = colour_on;
         end
      end
      g.code = code;
      g.offset = offset;
      g.face = face_number;
      g.dropped = lost;
      g.last = 1'b0;
      glyphs_due.insert(glyphs_due.size(), g);
   endfunction

   // Handles a glyph as the decoder produces it. With no face the glyph is discarded.
   // In right-to-left mode it goes onto the stack, or is lost if the stack is full.
   function automatic void place_glyph(logic [CODE_BITS-1:0] code, logic [15:0] offset);
      if (!face_on) return;
      if (rtl_on) begin
         if (rtl_depth < STACK_SLOTS) begin
            rtl_stack[rtl_depth] = '{code, offset};
            rtl_depth++;
         end else begin
            rtl_lost = 1'b1;
         end
      end else begin
         send_glyph(code, offset, 1'b0);
      end
   endfunction

   function automatic void open_sequence(logic [2:0] length, logic [CODE_BITS-1:0] bits,
                                         logic [15:0] pos);
      seq_code = bits;
      seq_len = length;
      seq_count = 3'd1;
      seq_offset = pos;
   endfunction

   function automatic void close_sequence();
      seq_len = '0;
      seq_count = '0;
      seq_code = '0;
   endfunction

   function automatic void read_lead(logic [7:0] b, logic [15:0] pos);
      if (b[7] == 1'b0) place_glyph(21'(b), pos);
      else if (b[7:5] == 3'b110) open_sequence(3'd2, 21'(b[4:0]), pos);
      else if (b[7:4] == 4'b1110) open_sequence(3'd3, 21'(b[3:0]), pos);
      else if (b[7:3] == 5'b11110) open_sequence(3'd4, 21'(b[2:0]), pos);
      else place_glyph(REPLACEMENT_CODE, pos);
   endfunction

   // Works out the glyphs caused by one accepted byte item.
   function automatic void shape_byte(logic [7:0] b, logic eot);
      logic [15:0] pos;
      int unsigned first;
      glyph_type   tail_glyph;
      pos = text_pos;
      first = glyphs_due.size();
      if (seq_len != 0) begin
         if (b[7:6] == 2'b10) begin
            seq_code = {seq_code[14:0], b[5:0]};
            seq_count++;
            if (seq_count >= seq_len) begin
               place_glyph(seq_code, seq_offset);
               close_sequence();
            end
         end else begin
            // A broken sequence gives one replacement glyph, and the byte starts afresh.
            place_glyph(REPLACEMENT_CODE, seq_offset);
            close_sequence();
            read_lead(b, pos);
         end
      end else begin
         read_lead(b, pos);
      end
      text_pos = pos + 16'd1;
      if (eot) begin
         if (seq_len != 0) begin
            for (int k = 0; k < seq_count && k < 4; k++)
               place_glyph(REPLACEMENT_CODE, seq_offset + 16'(k));
            close_sequence();
         end
         if (face_on) begin
            while (rtl_depth > 0) begin
               rtl_depth--;
               send_glyph(rtl_stack[rtl_depth].code, rtl_stack[rtl_depth].offset, rtl_lost);
            end
         end
         rtl_depth = 0;
         rtl_lost = 1'b0;
         text_pos = '0;
         seq_offset = '0;
         if (glyphs_due.size() > first) begin
            tail_glyph = glyphs_due.pop_back();
            tail_glyph.last = 1'b1;
            glyphs_due.insert(glyphs_due.size(), tail_glyph);
         end
      end
   endfunction

   // ------------------------------------------------------------------------------------
   // Random text
   // ------------------------------------------------------------------------------------

   // A code from lo..hi. In about four draws out of ten it is one of the range's edges, or
   // the code just outside an edge.
   function automatic logic [CODE_BITS-1:0] near_range(logic [CODE_BITS-1:0] lo,
                                                       logic [CODE_BITS-1:0] hi);
      case ($urandom_range(9))
         0: return lo - 21'd1;
         1: return lo;
         2: return hi;
         3: return hi + 21'd1;
         default: return 21'($urandom_range(32'(hi), 32'(lo)));
      endcase
   endfunction

   function automatic logic [CODE_BITS-1:0] pick_code();
      case ($urandom_range(7))
         0: return 21'($urandom_range(8'h7F));
         1: return near_range(21'h000080, LATIN_LIMIT);
         2: return near_range(KANA_LO, KANA_HI);
         3: return near_range(HAN_LO, HAN_HI);
         4: return near_range(HANGUL_LO, HANGUL_HI);
         5: return near_range(SYMBOL_LO, SYMBOL_HI);
         6: return near_range(EMOJI_LO, EMOJI_HI);
         default: return 21'($urandom_range(32'h1FFFFF, 32'h80));
      endcase
   endfunction

   // Encodes one code point in the shortest form. Its last few bytes are left off where a
   // cut is asked for, so that the lead byte always remains.
   function automatic void append_code(logic [CODE_BITS-1:0] cp, int unsigned cut);
      logic [7:0] seq[$];
      if (cp < 21'h80)
         seq = '{cp[7:0]};
      else if (cp < 21'h800)
         seq = '{{3'b110, cp[10:6]}, {2'b10, cp[5:0]}};
      else if (cp < 21'h10000)
         seq = '{{4'b1110, cp[15:12]}, {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
      else
         seq = '{{5'b11110, cp[20:18]}, {2'b10, cp[17:12]}, {2'b10, cp[11:6]},
                 {2'b10, cp[5:0]}};
      repeat (cut) if (seq.size() > 1) void'(seq.pop_back());
      foreach (seq[i]) text_bytes.insert(text_bytes.size(), seq[i]);
   endfunction

   // Fills text_bytes with one string. Most characters are well formed. The rest are cut-off
   // sequences, stray bytes and plain noise. A long string is all ASCII and has more glyphs
   // than the right-to-left stack can hold.
   function automatic void compose_text(logic long_text);
      int unsigned n;
      text_bytes.delete();
      n = long_text ? $urandom_range(75, 66) : $urandom_range(12, 1);
      repeat (n) begin
         if (long_text) begin
            text_bytes.insert(text_bytes.size(), 8'($urandom_range(8'h7F)));
         end else begin
            case ($urandom_range(9))
               0, 1, 2, 3, 4, 5: append_code(pick_code(), 0);
               6, 7: append_code(pick_code(), $urandom_range(3, 1));
               8: text_bytes.insert(text_bytes.size(),
                                    $urandom_range(1) ? 8'($urandom_range(8'hBF, 8'h80))
                                                      : 8'($urandom_range(8'hFF, 8'hF8)));
               default: text_bytes.insert(text_bytes.size(), 8'($urandom_range(8'hFF)));
            endcase
         end
      end
   endfunction

   // ------------------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------------------

   // Offers one byte item and returns at the clock edge that accepts it. Valid stays high
   // when the caller sends its next item at once. It is lowered only by an idle cycle or by
   // the caller at the end of a run of items.
   task automatic send_byte(logic [7:0] b, logic eot);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= b;
      req_end_of_text <= eot;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      case (idx)
         CSR_EM_SIZE:       em_size = value;
         CSR_FACE_ID:       face_number = value;
         CSR_FACE_PRESENT:  face_on = value[0];
         CSR_EMOJI_COLOUR:  colour_on = value[0];
         CSR_RIGHT_TO_LEFT: rtl_on = value[0];
         default: ;
      endcase
   endtask

   task automatic set_config(logic [15:0] em, logic [15:0] face, logic present, logic colour,
                             logic rtl);
      write_reg(CSR_EM_SIZE, em);
      write_reg(CSR_FACE_ID, face);
      write_reg(CSR_FACE_PRESENT, 16'(present));
      write_reg(CSR_EMOJI_COLOUR, 16'(colour));
      write_reg(CSR_RIGHT_TO_LEFT, 16'(rtl));
      csr_write_enable <= 1'b0;
   endtask

   // Waits until every predicted glyph has arrived. It then lets a few more cycles pass,
   // since a byte that gives no glyph may still be in the pipeline.
   task automatic settle(int unsigned extra);
      while (glyphs_due.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // Sends random strings until the byte budget is spent. The last string may be left open,
   // so the next register setting can arrive in the middle of a string. In right-to-left
   // mode the first string is a long one, so that the stack overflows while a face is present.
   task automatic run_random(int unsigned budget);
      int unsigned sent;
      logic [7:0]  b;
      logic        eot;
      sent = 0;
      while (sent < budget) begin
         compose_text(rtl_on && (sent == 0 || $urandom_range(3) == 0));
         while (text_bytes.size() != 0 && sent < budget) begin
            b = text_bytes.pop_front();
            eot = (text_bytes.size() == 0);
            send_byte(b, eot);
            shape_byte(b, eot);
            sent++;
         end
      end
      req_valid <= 1'b0;
   endtask

   task automatic next_phase(logic [15:0] em, logic [15:0] face, logic present, logic colour,
                             logic rtl, int unsigned idle_pct, int unsigned stall_pct,
                             int unsigned budget);
      settle(16);
      set_config(em, face, present, colour, rtl);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      run_random(budget);
   endtask

   // ------------------------------------------------------------------------------------
   // Result side: random stall and the check of every accepted glyph.
   // ------------------------------------------------------------------------------------
   always @(posedge clock) begin : glyph_check
      glyph_type got;
      glyph_type want;
      got = '{rsp_glyph_code, rsp_byte_offset, rsp_advance, rsp_colour_glyph, rsp_glyph_face,
              rsp_dropped, rsp_last_glyph};
      if (!reset && rsp_valid && !rsp_stall) begin
         if (glyphs_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t unexpected glyph: code %h offset %0d last %b", $realtime,
                        got.code, got.offset, got.last);
         end else begin
            want = glyphs_due.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%0t glyph mismatch, expected: code %h off %0d adv %0d col %b",
                           $realtime, want.code, want.offset, want.advance, want.colour,
                           " face %0d drop %b last %b", want.face, want.dropped, want.last);
                  $display("%0t glyph mismatch, actual:   code %h off %0d adv %0d col %b",
                           $realtime, got.code, got.offset, got.advance, got.colour,
                           " face %0d drop %b last %b", got.face, got.dropped, got.last);
               end
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // The run is ended if neither channel moves an item for too long.
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("utf8_glyph_shaper_top verification failed");
      $finish;
   end

   // ------------------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------------------
   initial begin
      int unsigned row;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_text_byte <= '0;
      req_end_of_text <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_EM_SIZE;
      csr_write_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed string under the reset registers, with no idling on either side. A typed
      // row replaces the predicted glyph with the one given in the table.
      for (row = 0; row < $size(opening_rows); row++) begin
         send_byte(opening_rows[row].text_byte, opening_rows[row].eot);
         shape_byte(opening_rows[row].text_byte, opening_rows[row].eot);
         if (opening_rows[row].typed) begin
            void'(glyphs_due.pop_back());
            glyphs_due.insert(glyphs_due.size(),
                              glyph_type'{opening_rows[row].code, 16'd0, 16'd614, 1'b0,
                                          16'd0, 1'b0, 1'b1});
         end
      end
      req_valid <= 1'b0;

      // Random phases. They go through the em size extremes, the face number extremes, the
      // absent face, colour emoji and right-to-left mode. The idling pattern changes too:
      // none, an idle sender, a stalling receiver, and both sides idling now and then.
      next_phase(EM_SIZE_RESET, 16'h0000, 1'b1, 1'b0, 1'b0, 0, 0, 45);
      next_phase(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0, 61, 0, 45);
      next_phase(16'h0000, 16'h0001, 1'b1, 1'b1, 1'b1, 0, 61, 80);
      next_phase(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)), 1'b0, 1'b0,
                 1'b1, 9, 9, 25);
      next_phase(16'($urandom_range(16'hFFFF)), 16'h5A5A, 1'b1, 1'b1, 1'b1, 9, 9, 80);
      next_phase(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)), 1'b1, 1'b0,
                 1'b0, 0, 61, 45);

      settle(40);
      if (mismatch_count == 0 && glyphs_due.size() == 0)
         $display("utf8_glyph_shaper_top verification clean");
      else
         $display("utf8_glyph_shaper_top verification failed");
      $finish;
   end

endmodule

/* files.f */
+incdir+design
design/ugs_pkg.sv
design/ugs_ram.sv
design/ugs_ctrl.sv
design/ugs_datapath.sv
design/utf8_glyph_shaper_top.sv
verif/tb_top.sv
